### hw/rtl/grid_nearest_zero_distance_top_defines.svh
// Shared assertion macros for the distance transform block.
// Both expect clk and arst_n in scope.
`ifndef GRID_NEAREST_ZERO_DISTANCE_TOP_DEFINES_SVH
`define GRID_NEAREST_ZERO_DISTANCE_TOP_DEFINES_SVH

// Check cons in the same cycle as ante.
`define GNZD_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check cons in the cycle after ante.
`define GNZD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/gnzd_pkg.sv
`timescale 1ns / 1ps

package gnzd_pkg;

	localparam int DEF_MAX_ROWS = 64;
	localparam int DEF_MAX_COLS = 64;

	localparam int GRID_W  = 7;
	localparam int ROW_W   = 6;
	localparam int COL_W   = 6;
	localparam int DIST_W  = 7;
	localparam int SIZE_W  = 9;
	localparam int PADDR_W = 3;
	localparam int APB_DW  = 32;

	localparam logic [DIST_W-1:0] DIST_CAP   = 7'd127;
	localparam logic [GRID_W-1:0] GRID_RESET = 7'd64;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_READ = 1'b1;

	typedef enum logic {
		REG_GRID_ROWS,
		REG_GRID_COLS
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RESP,
		ST_FWD_RD,
		ST_FWD_WR,
		ST_BWD_RD,
		ST_BWD_WR
	} state_t;

	typedef enum logic [2:0] {
		POS_HOLD,
		POS_CLEAR,
		POS_FWD,
		POS_LAST,
		POS_BWD
	} pos_op_t;

	typedef enum logic [1:0] {
		RD_USER,
		RD_UP,
		RD_OWN,
		RD_HELD
	} rd_sel_t;

	typedef struct packed {
		logic    load;
		logic    capture_read;
		logic    out_load;
		logic    dist_wr;
		logic    bwd;
		pos_op_t pos_op;
		rd_sel_t rd_sel;
	} cmd_t;

	typedef struct packed {
		logic pos_first;
		logic pos_last;
		logic zero_next;
		logic out_busy;
	} sts_t;

	// One step further from a zero, saturating at the cap.
	function automatic logic [DIST_W-1:0] dist_step(input logic [DIST_W-1:0] d);
		return (d >= DIST_CAP) ? DIST_CAP : d + 1'b1;
	endfunction

endpackage

### hw/rtl/gnzd_if.sv
`timescale 1ns / 1ps

interface gnzd_in_if import gnzd_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             operation;
	logic             cell_bit;
	logic [ROW_W-1:0] read_row;
	logic [COL_W-1:0] read_col;

	modport source (output valid, operation, cell_bit, read_row, read_col, input ready);
	modport sink (input valid, operation, cell_bit, read_row, read_col, output ready);
endinterface

interface gnzd_out_if import gnzd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [DIST_W-1:0] distance;
	logic              unreached;
	logic              out_of_range;

	modport source (output valid, distance, unreached, out_of_range, input ready);
	modport sink (input valid, distance, unreached, out_of_range, output ready);
endinterface

### hw/rtl/grid_nearest_zero_distance_top.sv
`timescale 1ns / 1ps
// Channel  Dir  Handshake                      Carries
// in_ch    in   valid/ready                    operation, cell_bit, read_row, read_col
// out_ch   out  valid/ready                    distance, unreached, out_of_range
// apb      in   psel/penable/pwrite, pready=1  grid_rows at 0x0, grid_cols at 0x4
//
// Loads are taken back to back while idle; a read holds in_ch until its result is
// loaded into the out_ch register from the captured cell address.
// After the last cell of a grid holding a zero, the block runs a forward and a backward
// sweep over the shared distance memory, with one registered memory read and one
// write per cell in each pass; in_ch stalls.
// arst_n clears control state only; the grid and distance memories need no clearing pass.
// A result held on out_ch stalls the next read, and in_ch with it; loads keep flowing
// until that read arrives.

module grid_nearest_zero_distance_top import gnzd_pkg::*; #(
	parameter int MAX_ROWS = DEF_MAX_ROWS,
	parameter int MAX_COLS = DEF_MAX_COLS
) (
	input  logic               clk,
	input  logic               arst_n,
	gnzd_in_if.sink            in_ch,
	gnzd_out_if.source         out_ch,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [APB_DW-1:0]  pwdata,
	output logic [APB_DW-1:0]  prdata,
	output logic               pready
);

	localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

	cmd_t          cmd;
	sts_t          sts;
	logic          cfg_wr;
	logic [RW-1:0] rows_last;
	logic [CW-1:0] cols_last;
	logic          in_ready;

	// Hold the grid size; any write restarts loading.
	gnzd_cfg #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.cfg_wr    (cfg_wr),
		.rows_last (rows_last),
		.cols_last (cols_last)
	);

	// Sequence loads, reads and the two sweeps.
	gnzd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_op    (in_ch.operation),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Hold the memories, the raster position and the output register.
	gnzd_dp #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.cfg_wr           (cfg_wr),
		.rows_last        (rows_last),
		.cols_last        (cols_last),
		.in_cell_bit      (in_ch.cell_bit),
		.in_read_row      (in_ch.read_row),
		.in_read_col      (in_ch.read_col),
		.out_ready        (out_ch.ready),
		.out_valid        (out_ch.valid),
		.out_distance     (out_ch.distance),
		.out_unreached    (out_ch.unreached),
		.out_out_of_range (out_ch.out_of_range)
	);

	assign in_ch.ready = in_ready;

endmodule

### hw/rtl/gnzd_cfg.sv
`timescale 1ns / 1ps

module gnzd_cfg import gnzd_pkg::*; #(
	parameter int MAX_ROWS = DEF_MAX_ROWS,
	parameter int MAX_COLS = DEF_MAX_COLS,
	localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
	localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [APB_DW-1:0]  pwdata,
	output logic [APB_DW-1:0]  prdata,
	output logic               pready,
	output logic               cfg_wr,
	output logic [RW-1:0]      rows_last,
	output logic [CW-1:0]      cols_last
);

	logic [GRID_W-1:0] rows_q;
	logic [GRID_W-1:0] cols_q;
	logic [SIZE_W-1:0] rows_cnt;
	logic [SIZE_W-1:0] cols_cnt;
	reg_idx_t          reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[2]);
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= GRID_RESET;
			cols_q <= GRID_RESET;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_GRID_ROWS: rows_q <= pwdata[GRID_W-1:0];
				REG_GRID_COLS: cols_q <= pwdata[GRID_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_GRID_ROWS: prdata = {{(APB_DW-GRID_W){1'b0}}, rows_q};
			REG_GRID_COLS: prdata = {{(APB_DW-GRID_W){1'b0}}, cols_q};
		endcase
	end

	// Zero acts as one, anything above the maximum acts as the maximum.
	always_comb begin
		if (rows_q == '0)
			rows_cnt = SIZE_W'(1);
		else if (SIZE_W'(rows_q) > SIZE_W'(MAX_ROWS))
			rows_cnt = SIZE_W'(MAX_ROWS);
		else
			rows_cnt = SIZE_W'(rows_q);
		if (cols_q == '0)
			cols_cnt = SIZE_W'(1);
		else if (SIZE_W'(cols_q) > SIZE_W'(MAX_COLS))
			cols_cnt = SIZE_W'(MAX_COLS);
		else
			cols_cnt = SIZE_W'(cols_q);
	end

	assign rows_last = RW'(rows_cnt - SIZE_W'(1));
	assign cols_last = CW'(cols_cnt - SIZE_W'(1));

endmodule

### hw/rtl/gnzd_ctrl.sv
`timescale 1ns / 1ps

module gnzd_ctrl import gnzd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_op,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

`include "grid_nearest_zero_distance_top_defines.svh"

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d          = state_q;
		in_ready         = 1'b0;
		cmd.load         = 1'b0;
		cmd.capture_read = 1'b0;
		cmd.out_load     = 1'b0;
		cmd.dist_wr      = 1'b0;
		cmd.bwd          = 1'b0;
		cmd.pos_op       = POS_HOLD;
		cmd.rd_sel       = RD_USER;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_op == OP_READ) begin
						cmd.capture_read = 1'b1;
						state_d          = ST_RESP;
					end else begin
						cmd.load = 1'b1;
						if (sts.pos_last) begin
							cmd.pos_op = POS_CLEAR;
							if (sts.zero_next)
								state_d = ST_FWD_RD;
						end else begin
							cmd.pos_op = POS_FWD;
						end
					end
				end
			end
			ST_RESP: begin
				// keep reading the captured cell while the output is held
				cmd.rd_sel = RD_HELD;
				if (!sts.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			ST_FWD_RD: begin
				cmd.rd_sel = RD_UP;
				state_d    = ST_FWD_WR;
			end
			ST_FWD_WR: begin
				cmd.dist_wr = 1'b1;
				if (sts.pos_last) begin
					cmd.pos_op = POS_LAST;
					state_d    = ST_BWD_RD;
				end else begin
					cmd.pos_op = POS_FWD;
					state_d    = ST_FWD_RD;
				end
			end
			ST_BWD_RD: begin
				cmd.rd_sel = RD_OWN;
				cmd.bwd    = 1'b1;
				state_d    = ST_BWD_WR;
			end
			ST_BWD_WR: begin
				cmd.dist_wr = 1'b1;
				cmd.bwd     = 1'b1;
				if (sts.pos_first) begin
					cmd.pos_op = POS_CLEAR;
					state_d    = ST_IDLE;
				end else begin
					cmd.pos_op = POS_BWD;
					state_d    = ST_BWD_RD;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	`GNZD_ASSERT_SAME(a_out_load_free, cmd.out_load, !sts.out_busy, "result loaded over a held one")
	`GNZD_ASSERT_SAME(a_no_load_in_sweep, cmd.dist_wr, !cmd.load, "cell load during sweep")
	`GNZD_ASSERT_NEXT(a_read_to_resp, in_valid && in_ready && (in_op == OP_READ),
		state_q == ST_RESP, "read not followed by response")

endmodule

### hw/rtl/gnzd_dp.sv
`timescale 1ns / 1ps

module gnzd_dp import gnzd_pkg::*; #(
	parameter int MAX_ROWS = DEF_MAX_ROWS,
	parameter int MAX_COLS = DEF_MAX_COLS,
	localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
	localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output sts_t              sts,
	input  logic              cfg_wr,
	input  logic [RW-1:0]     rows_last,
	input  logic [CW-1:0]     cols_last,
	input  logic              in_cell_bit,
	input  logic [ROW_W-1:0]  in_read_row,
	input  logic [COL_W-1:0]  in_read_col,
	input  logic              out_ready,
	output logic              out_valid,
	output logic [DIST_W-1:0] out_distance,
	output logic              out_unreached,
	output logic              out_out_of_range
);

`include "grid_nearest_zero_distance_top_defines.svh"

	localparam int CELLS = MAX_ROWS * MAX_COLS;
	localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;

	logic [RW-1:0]     pos_row_q;
	logic [CW-1:0]     pos_col_q;
	logic [AW-1:0]     pos_base_q;
	logic [AW-1:0]     last_base;
	logic [AW-1:0]     cur_addr;
	logic [AW-1:0]     user_addr;
	logic [AW-1:0]     read_addr_q;
	logic [AW-1:0]     rd_a_addr;
	logic [AW-1:0]     down_addr;

	logic              cell_mem [CELLS];
	logic [DIST_W-1:0] dist_mem [CELLS];
	logic              cell_rd_q;
	logic [DIST_W-1:0] dist_a_q;
	logic [DIST_W-1:0] dist_b_q;
	logic [DIST_W-1:0] prev_q;

	logic [DIST_W-1:0] center;
	logic [DIST_W-1:0] nb;
	logic [DIST_W-1:0] nb_step;
	logic [DIST_W-1:0] prev_step;
	logic [DIST_W-1:0] min1;
	logic [DIST_W-1:0] new_dist;
	logic              nb_ok;
	logic              prev_ok;

	logic              zero_seen_q;
	logic              grid_ready_q;
	logic              in_oor;
	logic              oor_q;
	logic              unr_q;

	logic              out_valid_q;
	logic [DIST_W-1:0] out_dist_q;
	logic              out_unr_q;
	logic              out_oor_q;

	assign sts.pos_first = (pos_row_q == '0) && (pos_col_q == '0);
	assign sts.pos_last  = (pos_row_q == rows_last) && (pos_col_q == cols_last);
	assign sts.zero_next = (sts.pos_first ? 1'b0 : zero_seen_q) | ~in_cell_bit;
	assign sts.out_busy  = out_valid_q && !out_ready;

	assign last_base = AW'(int'(rows_last) * MAX_COLS);
	assign cur_addr  = pos_base_q + AW'(pos_col_q);
	assign user_addr = AW'(int'(in_read_row) * MAX_COLS + int'(in_read_col));
	assign down_addr = cur_addr + AW'(MAX_COLS);

	always_comb begin
		case (cmd.rd_sel)
			RD_USER: rd_a_addr = user_addr;
			RD_UP:   rd_a_addr = cur_addr - AW'(MAX_COLS);
			RD_OWN:  rd_a_addr = cur_addr;
			RD_HELD: rd_a_addr = read_addr_q;
			default: rd_a_addr = cur_addr;
		endcase
	end

	// Raster position shared by loading and both sweeps.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_row_q  <= '0;
			pos_col_q  <= '0;
			pos_base_q <= '0;
		end else if (cfg_wr) begin
			pos_row_q  <= '0;
			pos_col_q  <= '0;
			pos_base_q <= '0;
		end else begin
			case (cmd.pos_op)
				POS_HOLD: ;
				POS_CLEAR: begin
					pos_row_q  <= '0;
					pos_col_q  <= '0;
					pos_base_q <= '0;
				end
				POS_FWD: begin
					if (pos_col_q == cols_last) begin
						pos_col_q  <= '0;
						pos_row_q  <= pos_row_q + RW'(1);
						pos_base_q <= pos_base_q + AW'(MAX_COLS);
					end else begin
						pos_col_q <= pos_col_q + CW'(1);
					end
				end
				POS_LAST: begin
					pos_row_q  <= rows_last;
					pos_col_q  <= cols_last;
					pos_base_q <= last_base;
				end
				POS_BWD: begin
					if (pos_col_q == '0) begin
						pos_col_q  <= cols_last;
						pos_row_q  <= pos_row_q - RW'(1);
						pos_base_q <= pos_base_q - AW'(MAX_COLS);
					end else begin
						pos_col_q <= pos_col_q - CW'(1);
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load)
			cell_mem[cur_addr] <= in_cell_bit;
		cell_rd_q <= cell_mem[cur_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.dist_wr)
			dist_mem[cur_addr] <= new_dist;
		dist_a_q <= dist_mem[rd_a_addr];
		dist_b_q <= dist_mem[down_addr];
	end

	// Forward pass: seed from the cell, relax from above and left.
	// Backward pass: relax from below and right.
	always_comb begin
		center    = cmd.bwd ? dist_a_q : (cell_rd_q ? DIST_CAP : '0);
		nb        = cmd.bwd ? dist_b_q : dist_a_q;
		nb_ok     = cmd.bwd ? (pos_row_q != rows_last) : (pos_row_q != '0);
		prev_ok   = cmd.bwd ? (pos_col_q != cols_last) : (pos_col_q != '0);
		nb_step   = dist_step(nb);
		prev_step = dist_step(prev_q);
		min1      = (nb_ok && (nb_step < center)) ? nb_step : center;
		new_dist  = (prev_ok && (prev_step < min1)) ? prev_step : min1;
	end

	always_ff @(posedge clk) begin
		if (cmd.dist_wr)
			prev_q <= new_dist;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_seen_q  <= 1'b0;
			grid_ready_q <= 1'b0;
		end else if (cfg_wr) begin
			zero_seen_q  <= 1'b0;
			grid_ready_q <= 1'b0;
		end else if (cmd.load) begin
			zero_seen_q  <= sts.zero_next;
			grid_ready_q <= sts.pos_last;
		end
	end

	assign in_oor = (SIZE_W'(in_read_row) > SIZE_W'(rows_last)) ||
		(SIZE_W'(in_read_col) > SIZE_W'(cols_last));

	always_ff @(posedge clk) begin
		if (cmd.capture_read) begin
			oor_q       <= in_oor;
			unr_q       <= !(grid_ready_q && zero_seen_q);
			read_addr_q <= user_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.out_load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_dist_q <= (oor_q || unr_q) ? '0 : dist_a_q;
			out_unr_q  <= unr_q && !oor_q;
			out_oor_q  <= oor_q;
		end
	end

	assign out_valid        = out_valid_q;
	assign out_distance     = out_dist_q;
	assign out_unreached    = out_unr_q;
	assign out_out_of_range = out_oor_q;

	`GNZD_ASSERT_SAME(a_pos_in_grid, 1'b1,
		(pos_row_q <= rows_last) && (pos_col_q <= cols_last), "position outside grid")
	`GNZD_ASSERT_NEXT(a_ready_after_last, cmd.load && sts.pos_last && !cfg_wr,
		grid_ready_q, "grid not ready after last cell")
	`GNZD_ASSERT_NEXT(a_out_hold, out_valid_q && !out_ready, out_valid_q,
		"result dropped while stalled")

endmodule
